// ===== hdl/e2c_pkg.sv =====
// shared types, constants and helpers for the epoch seconds to utc calendar block
// no dependencies; imported by e2c_ctrl, epoch_seconds_to_utc_calendar and tb_top

package e2c_pkg;

    // seconds counter width, valid from 32 to 40
    localparam int SECONDS_WIDTH = 32;
    // the dividend is cut into 16-bit chunks, most significant chunk first
    localparam int CHUNK_W       = 16;
    localparam int CHUNKS        = (SECONDS_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int QUO_W         = CHUNKS * CHUNK_W;
    localparam int CNT_W         = $clog2(CHUNKS);
    // 86400 > 2**16, so the day count fits in 16 fewer bits than the seconds
    localparam int DAYS_W        = SECONDS_WIDTH - 16;

    // remainder prefix plus one chunk, times the reciprocal
    localparam int DIVX_W        = CHUNK_W + 6;
    localparam int RECIP_W       = 26;
    localparam int PROD_W        = DIVX_W + RECIP_W;
    // x / d = (x * ceil(2**28 / d)) >> 28, exact for x < 2**22 and the divisors below
    localparam int RECIP_SHIFT   = 28;

    localparam logic [5:0] DIV_MIN  = 6'd60;
    localparam logic [5:0] DIV_HOUR = 6'd24;
    localparam logic [5:0] DIV_WEEK = 6'd7;

    localparam logic [RECIP_W-1:0] RECIP_MIN  = 26'd4473925;
    localparam logic [RECIP_W-1:0] RECIP_HOUR = 26'd11184811;
    localparam logic [RECIP_W-1:0] RECIP_WEEK = 26'd38347923;

    localparam logic [7:0] EPOCH_YEAR_OFS = 8'd70;   // 1970 - 1900
    localparam logic [6:0] EPOCH_MOD100   = 7'd70;   // 1970 mod 100
    localparam logic [8:0] EPOCH_MOD400   = 9'd370;  // 1970 mod 400
    localparam logic [6:0] LAST_MOD100    = 7'd99;
    localparam logic [8:0] LAST_MOD400    = 9'd399;
    localparam logic [8:0] DAYS_LEAP      = 9'd366;
    localparam logic [8:0] DAYS_COMMON    = 9'd365;
    localparam logic [3:0] MONTH_DEC      = 4'd11;
    localparam logic [3:0] WDAY_EPOCH     = 4'd4;    // epoch was a thursday

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEC,
        ST_MIN,
        ST_HOUR,
        ST_WDAY,
        ST_YEAR,
        ST_MON,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_DIV,
        OP_YEAR,
        OP_MON
    } op_t;

    typedef enum logic [2:0] {
        FLD_NONE,
        FLD_SEC,
        FLD_MIN,
        FLD_HOUR,
        FLD_WDAY
    } field_t;

    typedef struct packed {
        logic               load;
        op_t                op;
        logic [5:0]         divisor;
        logic [RECIP_W-1:0] recip;
        logic               div_last;
        field_t             dst;
        logic               done;
    } ctrl_t;

    typedef struct packed {
        logic ge;
        logic mon_last;
    } status_t;

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        begin
            case (mon) inside
                4'd1:                   len = leap ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
                default:                len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// ===== hdl/e2c_ctrl.sv =====
// sequencer for the epoch seconds to utc calendar block
// steps the reciprocal divider chunk by chunk, then the compare-subtract unit through years and months
// depends on e2c_pkg

module e2c_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  e2c_pkg::status_t status,
    output e2c_pkg::ctrl_t   ctrl,
    output logic             busy
);
    import e2c_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             cnt_last;

    assign cnt_last = (cnt_reg == CNT_W'(CHUNKS - 1));
    assign busy     = (state_reg != ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (start)
                begin
                    state_next = ST_SEC;
                end
            end
            ST_SEC, ST_MIN, ST_HOUR, ST_WDAY:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_last)
                begin
                    cnt_next = '0;
                    case (state_reg)
                        ST_SEC:  state_next = ST_MIN;
                        ST_MIN:  state_next = ST_HOUR;
                        ST_HOUR: state_next = ST_WDAY;
                        default: state_next = ST_YEAR;
                    endcase
                end
            end
            ST_YEAR:
            begin
                if (!status.ge)
                begin
                    state_next = ST_MON;
                end
            end
            ST_MON:
            begin
                if (!status.ge || status.mon_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        ctrl          = '0;
        ctrl.op       = OP_NONE;
        ctrl.dst      = FLD_NONE;
        ctrl.div_last = cnt_last;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.load = start;
            end
            ST_SEC:
            begin
                ctrl.op      = OP_DIV;
                ctrl.divisor = DIV_MIN;
                ctrl.recip   = RECIP_MIN;
                ctrl.dst     = FLD_SEC;
            end
            ST_MIN:
            begin
                ctrl.op      = OP_DIV;
                ctrl.divisor = DIV_MIN;
                ctrl.recip   = RECIP_MIN;
                ctrl.dst     = FLD_MIN;
            end
            ST_HOUR:
            begin
                ctrl.op      = OP_DIV;
                ctrl.divisor = DIV_HOUR;
                ctrl.recip   = RECIP_HOUR;
                ctrl.dst     = FLD_HOUR;
            end
            ST_WDAY:
            begin
                ctrl.op      = OP_DIV;
                ctrl.divisor = DIV_WEEK;
                ctrl.recip   = RECIP_WEEK;
                ctrl.dst     = FLD_WDAY;
            end
            ST_YEAR:
            begin
                ctrl.op = OP_YEAR;
            end
            ST_MON:
            begin
                ctrl.op = OP_MON;
            end
            ST_DONE:
            begin
                ctrl.done = 1'b1;
            end
            default:
            begin
                ctrl.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== hdl/epoch_seconds_to_utc_calendar.sv =====
// top level of the epoch seconds to utc calendar converter
// shared reciprocal divider and compare-subtract unit; depends on e2c_pkg and e2c_ctrl
//
//  channel  | ports                                            | transfer
//  ---------+--------------------------------------------------+---------------------
//  command  | start, busy, epoch_seconds                       | start high, busy low
//  result   | done, second, minute, hour, weekday,             | done high, one cycle
//           | years_since_1900, day_of_year, month_index,      |
//           | day_of_month                                     |
//
// one item runs from the accepting edge through four divisions (60, 60, 24, 7) by reciprocal
// multiply, one CHUNK_W-bit chunk per cycle, then one compare-subtract per whole year and per
// whole month plus the last compare of each loop, then the done state
// busy is high from the accepting edge until the done cycle ends
// reset clears the sequencer only; the receiver cannot stall, done lasts one cycle

module epoch_seconds_to_utc_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] epoch_seconds,
    output logic        done,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [2:0]  weekday,
    output logic [7:0]  years_since_1900,
    output logic [8:0]  day_of_year,
    output logic [3:0]  month_index,
    output logic [4:0]  day_of_month
);
    import e2c_pkg::*;

    ctrl_t                    ctrl;
    status_t                  status;

    logic [QUO_W-1:0]         q_reg;
    logic [QUO_W-1:0]         q_next;
    logic [5:0]               rem_reg;
    logic [5:0]               rem_next;
    logic [DAYS_W-1:0]        days_reg;
    logic [7:0]               yoff_reg;
    logic [6:0]               mod100_reg;
    logic [8:0]               mod400_reg;
    logic [3:0]               mon_reg;
    logic [5:0]               sec_reg;
    logic [5:0]               min_reg;
    logic [4:0]               hour_reg;
    logic [2:0]               wday_reg;
    logic [8:0]               yday_reg;

    logic [DIVX_W-1:0]        div_x;
    logic [PROD_W-1:0]        div_prod;
    logic [CHUNK_W-1:0]       div_q;
    logic [11:0]              div_qd;
    logic [DAYS_W-1:0]        op_a;
    logic [DAYS_W-1:0]        op_b;
    logic [DAYS_W:0]          diff;
    logic                     ge;
    logic                     leap;

    e2c_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    assign leap = ((yoff_reg[1:0] == 2'd0) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);

    // shared reciprocal divider, one chunk per cycle
    assign div_x    = {rem_reg, q_reg[QUO_W-1 -: CHUNK_W]};
    assign div_prod = PROD_W'(div_x) * PROD_W'(ctrl.recip);
    assign div_q    = div_prod[RECIP_SHIFT +: CHUNK_W];
    assign div_qd   = 12'(div_q[5:0]) * 12'(ctrl.divisor);
    assign rem_next = div_x[5:0] - div_qd[5:0];
    assign q_next   = {q_reg[QUO_W-CHUNK_W-1:0], div_q};

    // shared compare-subtract unit
    always_comb
    begin
        case (ctrl.op)
            OP_YEAR:
            begin
                op_a = days_reg;
                op_b = leap ? DAYS_W'(DAYS_LEAP) : DAYS_W'(DAYS_COMMON);
            end
            OP_MON:
            begin
                op_a = days_reg;
                op_b = DAYS_W'(month_len(mon_reg, leap));
            end
            default:
            begin
                op_a = days_reg;
                op_b = '0;
            end
        endcase
        diff = {1'b0, op_a} - {1'b0, op_b};
        ge   = !diff[DAYS_W];
    end

    assign status.ge       = ge;
    assign status.mon_last = (mon_reg == MONTH_DEC);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            q_reg      <= QUO_W'(epoch_seconds);
            rem_reg    <= '0;
            yoff_reg   <= EPOCH_YEAR_OFS;
            mod100_reg <= EPOCH_MOD100;
            mod400_reg <= EPOCH_MOD400;
            mon_reg    <= '0;
        end
        else
        begin
            case (ctrl.op)
                OP_DIV:
                begin
                    if (ctrl.div_last)
                    begin
                        rem_reg <= '0;
                        case (ctrl.dst)
                            FLD_SEC:  sec_reg <= rem_next;
                            FLD_MIN:  min_reg <= rem_next;
                            FLD_HOUR:
                            begin
                                hour_reg <= rem_next[4:0];
                                days_reg <= q_next[DAYS_W-1:0];
                            end
                            FLD_WDAY: wday_reg <= rem_next[2:0];
                            default:  sec_reg  <= sec_reg;
                        endcase
                    end
                    else
                    begin
                        rem_reg <= rem_next;
                    end
                    if (ctrl.div_last && (ctrl.dst == FLD_HOUR))
                    begin
                        q_reg <= q_next + QUO_W'(WDAY_EPOCH);
                    end
                    else
                    begin
                        q_reg <= q_next;
                    end
                end
                OP_YEAR:
                begin
                    if (ge)
                    begin
                        days_reg   <= diff[DAYS_W-1:0];
                        yoff_reg   <= yoff_reg + 8'd1;
                        mod100_reg <= (mod100_reg == LAST_MOD100) ? 7'd0 : mod100_reg + 7'd1;
                        mod400_reg <= (mod400_reg == LAST_MOD400) ? 9'd0 : mod400_reg + 9'd1;
                    end
                    else
                    begin
                        yday_reg <= days_reg[8:0];
                    end
                end
                OP_MON:
                begin
                    if (ge && !status.mon_last)
                    begin
                        days_reg <= diff[DAYS_W-1:0];
                        mon_reg  <= mon_reg + 4'd1;
                    end
                end
                default:
                begin
                    mon_reg <= mon_reg;
                end
            endcase
        end
    end

    assign done             = ctrl.done;
    assign second           = sec_reg;
    assign minute           = min_reg;
    assign hour             = hour_reg;
    assign weekday          = wday_reg;
    assign years_since_1900 = yoff_reg;
    assign day_of_year      = yday_reg;
    assign month_index      = mon_reg;
    assign day_of_month     = days_reg[4:0] + 5'd1;

endmodule

// ===== tb/tb_top.sv =====
// testbench for epoch_seconds_to_utc_calendar: directed and random epoch second counts,
// each checked field by field against an in-bench calendar computation
// depends on e2c_pkg and the epoch_seconds_to_utc_calendar rtl

module tb_top;

    import e2c_pkg::*;

    localparam int          MAX_CYCLES     = 1000000;
    localparam int          RANDOM_ITEMS   = 750;
    localparam int          DRAIN_CYCLES   = 300;
    localparam int          MAX_REPORTS    = 10;
    localparam int          DAYS_PER_EPOCH = 49710;
    localparam int unsigned SECS_PER_DAY   = 86400;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [7:0] years_since_1900;
        logic [8:0] day_of_year;
        logic [3:0] month_index;
        logic [4:0] day_of_month;
    } utc_fields_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        start         = 1'b0;
    logic [31:0] epoch_seconds = 32'd0;
    logic        busy;
    logic        done;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [7:0]  years_since_1900;
    logic [8:0]  day_of_year;
    logic [3:0]  month_index;
    logic [4:0]  day_of_month;

    logic [31:0] pending_seconds[$];
    utc_fields_t expected_calendar[$];
    int          items_total    = 0;
    int          items_accepted = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          gap_left       = 0;
    bit          gaps_enabled   = 1'b1;

    epoch_seconds_to_utc_calendar i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .epoch_seconds    (epoch_seconds),
        .done             (done),
        .second           (second),
        .minute           (minute),
        .hour             (hour),
        .weekday          (weekday),
        .years_since_1900 (years_since_1900),
        .day_of_year      (day_of_year),
        .month_index      (month_index),
        .day_of_month     (day_of_month)
    );

    always #5 clk = ~clk;

    function automatic bit gregorian_leap(input longint unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    function automatic utc_fields_t calendar_of(input logic [31:0] secs);
        utc_fields_t     f;
        longint unsigned t;
        longint unsigned y;
        longint unsigned len;
        int              mon;
        int              mon_span[12];
        begin
            mon_span = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            t = 64'(secs) & ((64'd1 << SECONDS_WIDTH) - 64'd1);
            f.second = 6'(t % 60);
            t = t / 60;
            f.minute = 6'(t % 60);
            t = t / 60;
            f.hour = 5'(t % 24);
            t = t / 24;
            f.weekday = 3'((t + 4) % 7);
            y = 1970;
            forever
            begin
                len = gregorian_leap(y) ? 366 : 365;
                if (t < len)
                    break;
                t = t - len;
                y = y + 1;
            end
            f.years_since_1900 = 8'(y - 1900);
            f.day_of_year = 9'(t);
            if (gregorian_leap(y))
                mon_span[1] = 29;
            mon = 0;
            while (mon < 11 && t >= longint'(mon_span[mon]))
            begin
                t = t - mon_span[mon];
                mon++;
            end
            f.month_index = 4'(mon);
            f.day_of_month = 5'(t + 1);
            return f;
        end
    endfunction

    task automatic report_mismatch(input string what, input longint exp_v, input longint act_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s expected %0d actual %0d",
                     cycle_count, what, exp_v, act_v);
    endtask

    // driver: one transfer per item, random gap between items unless gaps are switched off
    always @(posedge clk)
    begin
        bit fire;
        bit next_start;
        if (rst_n)
        begin
            fire = start && !busy;
            next_start = start;
            if (fire)
            begin
                expected_calendar.push_back(calendar_of(epoch_seconds));
                items_accepted++;
                if (items_accepted % 60 == 0)
                    gaps_enabled = ($urandom_range(0, 3) != 0);
                gap_left = gaps_enabled ? $urandom_range(0, 10) : 0;
                next_start = 1'b0;
            end
            if (!next_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_seconds.size() > 0)
                begin
                    next_start = 1'b1;
                    epoch_seconds <= pending_seconds.pop_front();
                end
            end
            start <= next_start;
        end
    end

    // monitor: every done strobe is a result transfer
    always @(posedge clk)
    begin
        utc_fields_t want;
        if (rst_n && done)
        begin
            if (expected_calendar.size() == 0)
                report_mismatch("result with nothing pending, second", -1, second);
            else
            begin
                want = expected_calendar.pop_front();
                if (second !== want.second)
                    report_mismatch("second", want.second, second);
                if (minute !== want.minute)
                    report_mismatch("minute", want.minute, minute);
                if (hour !== want.hour)
                    report_mismatch("hour", want.hour, hour);
                if (weekday !== want.weekday)
                    report_mismatch("weekday", want.weekday, weekday);
                if (years_since_1900 !== want.years_since_1900)
                    report_mismatch("years_since_1900", want.years_since_1900, years_since_1900);
                if (day_of_year !== want.day_of_year)
                    report_mismatch("day_of_year", want.day_of_year, day_of_year);
                if (month_index !== want.month_index)
                    report_mismatch("month_index", want.month_index, month_index);
                if (day_of_month !== want.day_of_month)
                    report_mismatch("day_of_month", want.day_of_month, day_of_month);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        longint unsigned candidate;
        longint unsigned year_start;
        int              target_year;
        int              day;
        int              sod;
        int              kind;

        // directed: field extremes, unit rollovers, leap and century rules
        pending_seconds = '{
            32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600,
            32'd86399, 32'd86400, 32'd31449600, 32'd31535999, 32'd31536000,
            32'd68169600, 32'd94608000, 32'd94694400, 32'd951782400, 32'd951868800,
            32'd978134400, 32'd978307199, 32'd4102444799, 32'd4107456000,
            32'd4107542400, 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555
        };

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            kind = $urandom_range(0, 9);
            sod = $urandom_range(0, 2) == 0 ? 0 :
                  ($urandom_range(0, 1) == 0 ? SECS_PER_DAY - 1 : $urandom_range(0, 86399));
            if (kind < 3)
                candidate = $urandom;
            else if (kind < 6)
            begin
                // around a new year or around the end of february, in a random year from 1971 to 2106
                target_year = $urandom_range(1971, 2106);
                year_start = 0;
                for (int y = 1970; y < target_year; y++)
                    year_start += gregorian_leap(y) ? 366 : 365;
                day = int'(year_start) + $urandom_range(0, 4) - 2
                      + ($urandom_range(0, 1) ? 59 : 0);
                candidate = longint'(day) * SECS_PER_DAY + sod;
            end
            else
            begin
                day = $urandom_range(0, DAYS_PER_EPOCH);
                candidate = longint'(day) * SECS_PER_DAY + sod;
            end
            if (candidate > 64'hFFFF_FFFF)
                candidate = $urandom;
            pending_seconds.push_back(32'(candidate));
        end
        items_total = pending_seconds.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (items_accepted < items_total || expected_calendar.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/e2c_pkg.sv
hdl/e2c_ctrl.sv
hdl/epoch_seconds_to_utc_calendar.sv
tb/tb_top.sv
